/* hw/rtl/spe_pkg.sv */
package spe_pkg;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_CONFIG  = 2'd1,
      CMD_SELECT  = 2'd2,
      CMD_ENCODER = 2'd3
   } cmd_type;

   localparam int unsigned CUR_W = 9;
   localparam int unsigned RES_W = 7;
   localparam int unsigned TICK_W = 16;

   localparam logic [CUR_W-1:0]  CUR_MAX = 9'd300;
   localparam logic [RES_W-1:0]  RES_MIN = 7'd1;
   localparam logic [RES_W-1:0]  RES_MAX = 7'd100;
   localparam logic [RES_W-1:0]  RES_RESET = 7'd10;
   localparam logic [1:0]        CURSOR_RESET = 2'd1;
   localparam logic [1:0]        CURSOR_MODE = 2'd0;
   localparam logic [1:0]        CURSOR_LAST_CC = 2'd3;
   localparam logic [1:0]        CURSOR_LAST_CR = 2'd2;
   localparam logic [TICK_W-1:0] SAVE_DELAY_RESET = 16'd2000;
   localparam logic [TICK_W-1:0] TICK_SAT = 16'hFFFF;

endpackage

/* hw/rtl/setpoint_editor_ui_fsm_core.sv */
// front-panel setpoint editor for an electronic load
//
// req channel: one event per transaction (req_cmd: tick, config button,
// select button, encoder; req_encoder_delta is a signed detent count used
// only for encoder events). accepted when req_valid is high and req_stall
// is low.
// rsp channel: one result per event with mode, active setpoint, limit
// flags, view, cursor, publish and save strobes and the stored setpoints.
// taken when rsp_valid is high and rsp_stall is low.
// csr channel: writes save_delay_ticks whenever csr_valid is high;
// csr_ready is always high. write only while the block is idle.
//
// an accepted event goes into the input register, then through one pass of
// update logic into the result register. throughput: one event per cycle
// while rsp_stall is low, set by the single update pass through the setpoint
// and timer registers.
// a stalled result holds; one more event may sit in the input register,
// after which req_stall goes high until the result is taken.
// reset (synchronous) empties both registers and loads the reset settings:
// constant current, 0.00 A, 10 ohm, monitor view, cursor 1, no pending save.
module setpoint_editor_ui_fsm_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_cmd,
   input  logic signed [7:0]               req_encoder_delta,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_mode,
   output logic [8:0]                      rsp_setpoint,
   output logic                            rsp_in_config,
   output logic [1:0]                      rsp_cursor,
   output logic                            rsp_at_min,
   output logic                            rsp_at_max,
   output logic                            rsp_published,
   output logic                            rsp_save_request,
   output logic [8:0]                      rsp_save_current,
   output logic [6:0]                      rsp_save_resistance,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [15:0]                     csr_save_delay_ticks
);

   localparam int unsigned CW = spe_pkg::CUR_W;
   localparam int unsigned RW = spe_pkg::RES_W;
   localparam int unsigned TW = spe_pkg::TICK_W;

   // input register
   logic                   in_valid_ff, in_valid_in;
   spe_pkg::cmd_type       in_cmd_ff;
   logic signed [7:0]      in_delta_ff;

   // settings state
   logic [TW-1:0]          delay_ff;
   logic                   mode_ff, mode_in;
   logic [CW-1:0]          cur_ff, cur_in;
   logic [RW-1:0]          res_ff, res_in;
   logic                   view_ff, view_in;
   logic [1:0]             cursor_ff, cursor_in;
   logic                   pending_ff, pending_in;
   logic [TW-1:0]          ticks_ff, ticks_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_mode_ff;
   logic [CW-1:0]          rsp_setpoint_ff;
   logic                   rsp_in_config_ff;
   logic [1:0]             rsp_cursor_ff;
   logic                   rsp_at_min_ff, rsp_at_min_in;
   logic                   rsp_at_max_ff, rsp_at_max_in;
   logic                   rsp_published_ff, rsp_published_in;
   logic                   rsp_save_ff, rsp_save_in;
   logic [CW-1:0]          rsp_save_cur_ff;
   logic [RW-1:0]          rsp_save_res_ff;

   logic                   out_free, move, req_accept;
   logic                   publish, save_now;
   logic [2:0]             cursor_inc;
   logic [2:0]             cursor_top;
   logic signed [15:0]     delta_x;
   logic signed [15:0]     cur_step, res_step;
   logic signed [15:0]     cur_sum, res_sum;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign move       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign in_valid_in  = req_accept ? 1'b1 : (move ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = move ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // digit arithmetic
   assign delta_x = 16'(in_delta_ff);

   always_comb begin
      case (cursor_ff)
         2'd1:    cur_step = 16'sd100;
         2'd2:    cur_step = 16'sd10;
         2'd3:    cur_step = 16'sd1;
         default: cur_step = 16'sd0;
      endcase
      case (cursor_ff)
         2'd1:    res_step = 16'sd10;
         2'd2:    res_step = 16'sd1;
         default: res_step = 16'sd0;
      endcase
   end

   assign cur_sum = $signed({{(16-CW){1'b0}}, cur_ff}) + 16'(delta_x * cur_step);
   assign res_sum = $signed({{(16-RW){1'b0}}, res_ff}) + 16'(delta_x * res_step);

   assign cursor_inc = {1'b0, cursor_ff} + 3'd1;
   assign cursor_top = mode_ff ? {1'b0, spe_pkg::CURSOR_LAST_CR}
                               : {1'b0, spe_pkg::CURSOR_LAST_CC};

   // event update
   always_comb begin
      logic pend_a;
      logic [TW-1:0] ticks_a;
      mode_in    = mode_ff;
      cur_in     = cur_ff;
      res_in     = res_ff;
      view_in    = view_ff;
      cursor_in  = cursor_ff;
      pend_a     = pending_ff;
      ticks_a    = ticks_ff;
      publish    = 1'b0;
      save_now   = 1'b0;
      unique case (in_cmd_ff)
         spe_pkg::CMD_TICK: begin
            if (pending_ff && ticks_ff != spe_pkg::TICK_SAT) begin
               ticks_a = ticks_ff + 16'd1;
            end
         end
         spe_pkg::CMD_CONFIG: begin
            view_in   = !view_ff;
            cursor_in = spe_pkg::CURSOR_RESET;
            if (view_ff) begin
               save_now = 1'b1;
               pend_a   = 1'b0;
            end
            publish = 1'b1;
         end
         spe_pkg::CMD_SELECT: begin
            if (view_ff) begin
               cursor_in = (cursor_inc > cursor_top) ? spe_pkg::CURSOR_MODE
                                                     : cursor_inc[1:0];
            end
            publish = 1'b1;
         end
         spe_pkg::CMD_ENCODER: begin
            if (view_ff) begin
               if (cursor_ff == spe_pkg::CURSOR_MODE) begin
                  if (in_delta_ff != 8'sd0) begin
                     mode_in   = !mode_ff;
                     cursor_in = spe_pkg::CURSOR_RESET;
                  end
               end else if (!mode_ff) begin
                  if (cur_sum < 16'sd0) begin
                     cur_in = '0;
                  end else if (cur_sum > $signed({7'd0, spe_pkg::CUR_MAX})) begin
                     cur_in = spe_pkg::CUR_MAX;
                  end else begin
                     cur_in = cur_sum[CW-1:0];
                  end
               end else begin
                  if (res_sum < $signed({9'd0, spe_pkg::RES_MIN})) begin
                     res_in = spe_pkg::RES_MIN;
                  end else if (res_sum > $signed({9'd0, spe_pkg::RES_MAX})) begin
                     res_in = spe_pkg::RES_MAX;
                  end else begin
                     res_in = res_sum[RW-1:0];
                  end
               end
               publish = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (publish && view_in) begin
         pend_a  = 1'b1;
         ticks_a = '0;
      end
      pending_in = pend_a;
      ticks_in   = ticks_a;
      if (pend_a && ticks_a > delay_ff) begin
         save_now   = 1'b1;
         pending_in = 1'b0;
      end
   end

   always_comb begin
      if (!mode_in) begin
         rsp_at_min_in = (cur_in == '0);
         rsp_at_max_in = (cur_in >= spe_pkg::CUR_MAX);
      end else begin
         rsp_at_min_in = (res_in <= spe_pkg::RES_MIN);
         rsp_at_max_in = (res_in >= spe_pkg::RES_MAX);
      end
      rsp_published_in = publish;
      rsp_save_in      = save_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         delay_ff     <= spe_pkg::SAVE_DELAY_RESET;
         mode_ff      <= 1'b0;
         cur_ff       <= '0;
         res_ff       <= spe_pkg::RES_RESET;
         view_ff      <= 1'b0;
         cursor_ff    <= spe_pkg::CURSOR_RESET;
         pending_ff   <= 1'b0;
         ticks_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            delay_ff <= csr_save_delay_ticks;
         end
         if (move) begin
            mode_ff    <= mode_in;
            cur_ff     <= cur_in;
            res_ff     <= res_in;
            view_ff    <= view_in;
            cursor_ff  <= cursor_in;
            pending_ff <= pending_in;
            ticks_ff   <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_cmd_ff   <= spe_pkg::cmd_type'(req_cmd);
         in_delta_ff <= req_encoder_delta;
      end
      if (move) begin
         rsp_mode_ff      <= mode_in;
         rsp_setpoint_ff  <= mode_in ? {{(CW-RW){1'b0}}, res_in} : cur_in;
         rsp_in_config_ff <= view_in;
         rsp_cursor_ff    <= cursor_in;
         rsp_at_min_ff    <= rsp_at_min_in;
         rsp_at_max_ff    <= rsp_at_max_in;
         rsp_published_ff <= rsp_published_in;
         rsp_save_ff      <= rsp_save_in;
         rsp_save_cur_ff  <= cur_in;
         rsp_save_res_ff  <= res_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mode            = rsp_mode_ff;
   assign rsp_setpoint        = rsp_setpoint_ff;
   assign rsp_in_config       = rsp_in_config_ff;
   assign rsp_cursor          = rsp_cursor_ff;
   assign rsp_at_min          = rsp_at_min_ff;
   assign rsp_at_max          = rsp_at_max_ff;
   assign rsp_published       = rsp_published_ff;
   assign rsp_save_request    = rsp_save_ff;
   assign rsp_save_current    = rsp_save_cur_ff;
   assign rsp_save_resistance = rsp_save_res_ff;

   // no pending save outside config view
   a_pending_only_in_config: assert property (@(posedge clock) disable iff (reset)
      !view_ff |-> !pending_ff)
      else $error("save pending in monitor view");

   // constant resistance mode never has the third digit selected
   a_cursor_range_cr: assert property (@(posedge clock) disable iff (reset)
      mode_ff |-> (cursor_ff != spe_pkg::CURSOR_LAST_CC))
      else $error("cursor out of range in resistance mode");

   a_res_range: assert property (@(posedge clock) disable iff (reset)
      (res_ff >= spe_pkg::RES_MIN) && (res_ff <= spe_pkg::RES_MAX))
      else $error("resistance setpoint out of range");

   // a published config change restarts the timer, so no backup save with it
   a_no_save_on_edit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_in_config_ff && rsp_published_ff) |-> !rsp_save_ff)
      else $error("backup save on the same event as an edit");

   a_limits_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_at_min_ff && rsp_at_max_ff))
      else $error("setpoint at both limits");

endmodule

/* sim/panel_scoreboard_pkg.sv */
package panel_scoreboard_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import spe_pkg::*;

   localparam logic MODE_CC = 1'b0;
   localparam logic MODE_CR = 1'b1;
   localparam int MAX_REPORTS = 200;

   typedef struct packed {
      logic             mode;
      logic [CUR_W-1:0] setpoint;
      logic             in_config;
      logic [1:0]       cursor;
      logic             at_min;
      logic             at_max;
      logic             published;
      logic             save_request;
      logic [CUR_W-1:0] save_current;
      logic [RES_W-1:0] save_resistance;
   } panel_result_t;

   class panel_scoreboard;
      logic              mode_q;
      logic [CUR_W-1:0]  current_q;
      logic [RES_W-1:0]  resistance_q;
      logic              view_q;
      logic [1:0]        cursor_q;
      logic              pending_q;
      logic [TICK_W-1:0] ticks_q;
      logic [TICK_W-1:0] delay_q;
      panel_result_t     expected_panels[$];
      int                errors;
      int                events_seen;
      int                results_checked;
      int                save_strobes;
      int                backup_saves;
      int                delay_writes;

      function new();
         mode_q = MODE_CC;
         current_q = '0;
         resistance_q = RES_RESET;
         view_q = 1'b0;
         cursor_q = CURSOR_RESET;
         pending_q = 1'b0;
         ticks_q = '0;
         delay_q = SAVE_DELAY_RESET;
         errors = 0;
         events_seen = 0;
         results_checked = 0;
         save_strobes = 0;
         backup_saves = 0;
         delay_writes = 0;
      endfunction

      function void set_delay(logic [TICK_W-1:0] value);
         delay_q = value;
         delay_writes++;
      endfunction

      function int pending();
         return expected_panels.size();
      endfunction

      // advance the panel state by one accepted event and queue its result
      function void note_event(cmd_type cmd, logic [7:0] delta);
         int d;
         int stepv;
         int nxt;
         logic publish;
         logic save_now;
         logic [1:0] top;
         panel_result_t r;
         d = $signed(delta);
         publish = 1'b0;
         save_now = 1'b0;
         events_seen++;
         case (cmd)
            CMD_TICK: begin
               if (pending_q && ticks_q != TICK_SAT) ticks_q = ticks_q + 1'b1;
            end
            CMD_CONFIG: begin
               view_q = ~view_q;
               cursor_q = CURSOR_RESET;
               if (!view_q) begin
                  save_now = 1'b1;
                  pending_q = 1'b0;
               end
               publish = 1'b1;
            end
            CMD_SELECT: begin
               if (view_q) begin
                  top = (mode_q == MODE_CC) ? CURSOR_LAST_CC : CURSOR_LAST_CR;
                  cursor_q = (cursor_q >= top) ? CURSOR_MODE : cursor_q + 2'd1;
               end
               publish = 1'b1;
            end
            default: begin
               if (view_q) begin
                  if (cursor_q == CURSOR_MODE) begin
                     if (d != 0) begin
                        mode_q = ~mode_q;
                        cursor_q = CURSOR_RESET;
                     end
                  end else if (mode_q == MODE_CC) begin
                     case (cursor_q)
                        2'd1: stepv = 100;
                        2'd2: stepv = 10;
                        default: stepv = 1;
                     endcase
                     nxt = int'(current_q) + d * stepv;
                     if (nxt < 0) nxt = 0;
                     if (nxt > int'(CUR_MAX)) nxt = int'(CUR_MAX);
                     current_q = nxt[CUR_W-1:0];
                  end else begin
                     case (cursor_q)
                        2'd1: stepv = 10;
                        2'd2: stepv = 1;
                        default: stepv = 0;
                     endcase
                     nxt = int'(resistance_q) + d * stepv;
                     if (nxt < int'(RES_MIN)) nxt = int'(RES_MIN);
                     if (nxt > int'(RES_MAX)) nxt = int'(RES_MAX);
                     resistance_q = nxt[RES_W-1:0];
                  end
                  publish = 1'b1;
               end
            end
         endcase

         if (publish && view_q) begin
            pending_q = 1'b1;
            ticks_q = '0;
         end
         if (pending_q && ticks_q > delay_q) begin
            save_now = 1'b1;
            pending_q = 1'b0;
            backup_saves++;
         end
         if (save_now) save_strobes++;

         r.mode = mode_q;
         r.setpoint = (mode_q == MODE_CC) ? current_q : CUR_W'(resistance_q);
         r.in_config = view_q;
         r.cursor = cursor_q;
         if (mode_q == MODE_CC) begin
            r.at_min = (current_q == '0);
            r.at_max = (current_q >= CUR_MAX);
         end else begin
            r.at_min = (resistance_q <= RES_MIN);
            r.at_max = (resistance_q >= RES_MAX);
         end
         r.published = publish;
         r.save_request = save_now;
         r.save_current = current_q;
         r.save_resistance = resistance_q;
         expected_panels.push_back(r);
      endfunction

      function void compare_field(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_result(panel_result_t got);
         panel_result_t want;
         if (expected_panels.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result transaction with nothing expected, actual %h", $time, got);
            return;
         end
         want = expected_panels.pop_front();
         results_checked++;
         compare_field("mode", want.mode, got.mode);
         compare_field("setpoint", want.setpoint, got.setpoint);
         compare_field("in_config", want.in_config, got.in_config);
         compare_field("cursor", want.cursor, got.cursor);
         compare_field("at_min", want.at_min, got.at_min);
         compare_field("at_max", want.at_max, got.at_max);
         compare_field("published", want.published, got.published);
         compare_field("save_request", want.save_request, got.save_request);
         compare_field("save_current", want.save_current, got.save_current);
         compare_field("save_resistance", want.save_resistance, got.save_resistance);
      endfunction
   endclass

endpackage

/* sim/setpoint_editor_ui_fsm_core_tb.sv */
module setpoint_editor_ui_fsm_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spe_pkg::*;
   import panel_scoreboard_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int NUM_PHASES = 7;
   localparam int PHASE_ITEMS = 280;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = CMD_TICK;
   logic [7:0]  req_encoder_delta = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_mode;
   logic [8:0]  rsp_setpoint;
   logic        rsp_in_config;
   logic [1:0]  rsp_cursor;
   logic        rsp_at_min;
   logic        rsp_at_max;
   logic        rsp_published;
   logic        rsp_save_request;
   logic [8:0]  rsp_save_current;
   logic [6:0]  rsp_save_resistance;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_save_delay_ticks = SAVE_DELAY_RESET;

   panel_scoreboard panel_sb;
   int feed_idle_pct = 23;
   int drain_stall_pct = 23;
   bit hold_request = 1'b0;
   int hold_left = 0;

   setpoint_editor_ui_fsm_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_encoder_delta   (req_encoder_delta),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_mode            (rsp_mode),
      .rsp_setpoint        (rsp_setpoint),
      .rsp_in_config       (rsp_in_config),
      .rsp_cursor          (rsp_cursor),
      .rsp_at_min          (rsp_at_min),
      .rsp_at_max          (rsp_at_max),
      .rsp_published       (rsp_published),
      .rsp_save_request    (rsp_save_request),
      .rsp_save_current    (rsp_save_current),
      .rsp_save_resistance (rsp_save_resistance),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_save_delay_ticks(csr_save_delay_ticks)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: check each taken transaction, then pick the next stall
   always @(posedge clock) begin : result_monitor
      panel_result_t got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_mode, rsp_setpoint, rsp_in_config, rsp_cursor, rsp_at_min, rsp_at_max,
                rsp_published, rsp_save_request, rsp_save_current, rsp_save_resistance};
         panel_sb.check_result(got);
      end
      if (hold_request) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < drain_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("setpoint_editor_ui_fsm_core_tb: done, errors");
      $finish;
   end

   task automatic push_event(input cmd_type c, input logic [7:0] d);
      if ($urandom_range(99) < feed_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < feed_idle_pct);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_encoder_delta <= d;
      do @(posedge clock); while (req_stall);
      panel_sb.note_event(c, d);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (panel_sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_save_delay(input logic [15:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_save_delay_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      panel_sb.set_delay(value);
   endtask

   task automatic random_event(input int tick_pct);
      cmd_type c;
      logic [7:0] d;
      int r;
      r = $urandom_range(99);
      if (r < tick_pct) begin
         c = CMD_TICK;
      end else begin
         r = $urandom_range(99);
         if (r < 10) c = CMD_CONFIG;
         else if (r < 45) c = CMD_SELECT;
         else c = CMD_ENCODER;
      end
      case ($urandom_range(9))
         0, 1, 2, 3: d = 8'($urandom_range(8)) - 8'd4;
         4: d = 8'h00;
         5: d = 8'h80;
         6: d = 8'h7F;
         default: d = 8'($urandom_range(255));
      endcase
      push_event(c, d);
   endtask

   initial begin : stimulus
      logic [15:0] phase_delay [NUM_PHASES];
      int phase_ticks [NUM_PHASES];
      int p;
      int i;
      panel_sb = new();
      phase_delay[0] = 16'd0;      phase_ticks[0] = 35;
      phase_delay[1] = TICK_SAT;   phase_ticks[1] = 70;
      phase_delay[2] = 16'd1;      phase_ticks[2] = 40;
      phase_delay[3] = 16'd3;      phase_ticks[3] = 50;
      phase_delay[4] = 16'd12;     phase_ticks[4] = 80;
      phase_delay[5] = 16'($urandom_range(20)); phase_ticks[5] = 60;
      phase_delay[6] = 16'd40;     phase_ticks[6] = 90;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // monitor view: tick and encoder do nothing, select only raises the publish strobe
      push_event(CMD_TICK, 8'h00);
      push_event(CMD_SELECT, 8'h00);
      push_event(CMD_ENCODER, 8'd5);
      // current editing with clamping at both ends
      push_event(CMD_CONFIG, 8'h00);
      push_event(CMD_ENCODER, 8'h80);
      push_event(CMD_ENCODER, 8'h7F);
      push_event(CMD_SELECT, 8'h00);
      push_event(CMD_ENCODER, 8'hFF);
      push_event(CMD_SELECT, 8'h00);
      push_event(CMD_ENCODER, 8'h80);
      push_event(CMD_SELECT, 8'h00);
      // cursor on mode: zero delta keeps it, nonzero toggles
      push_event(CMD_ENCODER, 8'h00);
      push_event(CMD_ENCODER, 8'd1);
      // resistance editing
      push_event(CMD_ENCODER, 8'h80);
      push_event(CMD_ENCODER, 8'h7F);
      push_event(CMD_SELECT, 8'h00);
      push_event(CMD_ENCODER, 8'hFD);
      push_event(CMD_SELECT, 8'h00);
      push_event(CMD_SELECT, 8'h00);
      push_event(CMD_TICK, 8'h00);
      push_event(CMD_TICK, 8'h00);
      push_event(CMD_CONFIG, 8'h00);
      push_event(CMD_CONFIG, 8'h00);
      push_event(CMD_TICK, 8'h00);
      push_event(CMD_CONFIG, 8'h00);

      for (p = 0; p < NUM_PHASES; p++) begin
         write_save_delay(phase_delay[p]);
         feed_idle_pct = (p == 2) ? 0 : 23;
         drain_stall_pct = (p == 2) ? 0 : 23;
         for (i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 3 && i == 100) hold_request = 1'b1;
            random_event(phase_ticks[p]);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (panel_sb.pending() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, panel_sb.pending());
         panel_sb.errors++;
      end
      $display("covered %0d events and %0d results over %0d save delay settings",
               panel_sb.events_seen, panel_sb.results_checked, panel_sb.delay_writes);
      $display("save strobes expected: %0d, of them backup saves: %0d",
               panel_sb.save_strobes, panel_sb.backup_saves);
      if (panel_sb.errors == 0)
         $display("setpoint_editor_ui_fsm_core_tb: done, clean");
      else
         $display("setpoint_editor_ui_fsm_core_tb: done, errors");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/spe_pkg.sv
hw/rtl/setpoint_editor_ui_fsm_core.sv
sim/panel_scoreboard_pkg.sv
sim/setpoint_editor_ui_fsm_core_tb.sv
